@@ hw/rtl/pngu_pkg.sv @@
// Package for the PNG scanline unfilter unit: filter codes, register
// indexes, per-item control struct and the Paeth predictor function.
// Used by pngu_predict and png_scanline_unfilter_unit; depends on nothing.
package pngu_pkg;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef enum logic {
        REG_BPP = 1'b0,
        REG_ROW = 1'b1
    } t_reg_idx;

    localparam int BYTE_W    = 8;
    localparam int BPP_W     = 4;
    localparam int ROW_W     = 14;
    localparam int FTYPE_W   = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    typedef struct packed {
        logic                start;
        logic                first_row;
        logic                last;
        logic                fwd;
        t_filter             ftype;
        logic [BYTE_W-1:0]   xbyte;
    } t_item_ctl;

    function automatic logic [BYTE_W-1:0] paeth(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+2:0] da;
        logic signed [BYTE_W+2:0] db;
        logic signed [BYTE_W+2:0] dc;
        logic [BYTE_W+1:0]        pa;
        logic [BYTE_W+1:0]        pb;
        logic [BYTE_W+1:0]        pc;
        logic [BYTE_W-1:0]        res;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = da[BYTE_W+2] ? (BYTE_W+2)'(-da) : da[BYTE_W+1:0];
        pb = db[BYTE_W+2] ? (BYTE_W+2)'(-db) : db[BYTE_W+1:0];
        pc = dc[BYTE_W+2] ? (BYTE_W+2)'(-dc) : dc[BYTE_W+1:0];
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/pngu_line_mem.sv @@
// Prior-row line store: one write port, one read port, registered read data.
// Depends on nothing; instantiated by png_scanline_unfilter_unit.
module pngu_line_mem #(
    parameter int DEPTH  = 8192,
    parameter int AW     = 13,
    parameter int DW     = 8
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/pngu_predict.sv @@
// Reconstruction stage: left and upper-left pixel history, filter predictor
// and byte add. Depends on pngu_pkg; instantiated by png_scanline_unfilter_unit.
module pngu_predict #(
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int PW              = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  pngu_pkg::t_item_ctl         i_ctl,
    input  logic [pngu_pkg::BYTE_W-1:0] i_rd_byte,
    input  logic [pngu_pkg::BYTE_W-1:0] i_fwd_byte,
    input  logic [PW-1:0]               i_bpp_idx,
    output logic [pngu_pkg::BYTE_W-1:0] o_raw
);

    logic [pngu_pkg::BYTE_W-1:0] r_left  [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] r_upper [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] n_left  [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] n_upper [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] base_left  [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] base_upper [MAX_PIXEL_BYTES];
    logic [pngu_pkg::BYTE_W-1:0] a_byte;
    logic [pngu_pkg::BYTE_W-1:0] b_byte;
    logic [pngu_pkg::BYTE_W-1:0] c_byte;
    logic [pngu_pkg::BYTE_W-1:0] pred;
    logic [pngu_pkg::BYTE_W:0]   avg_sum;

    always_comb begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            base_left[i]  = i_ctl.start ? '0 : r_left[i];
            base_upper[i] = i_ctl.start ? '0 : r_upper[i];
        end
        a_byte = base_left[i_bpp_idx];
        c_byte = base_upper[i_bpp_idx];
        if (i_ctl.first_row) begin
            b_byte = '0;
        end else if (i_ctl.fwd) begin
            b_byte = i_fwd_byte;
        end else begin
            b_byte = i_rd_byte;
        end
        avg_sum = {1'b0, a_byte} + {1'b0, b_byte};
        case (i_ctl.ftype)
            pngu_pkg::FILT_SUB:   pred = a_byte;
            pngu_pkg::FILT_UP:    pred = b_byte;
            pngu_pkg::FILT_AVG:   pred = avg_sum[pngu_pkg::BYTE_W:1];
            pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(a_byte, b_byte, c_byte);
            default:              pred = '0;
        endcase
        o_raw = i_ctl.xbyte + pred;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            if (i_ctl.last) begin
                n_left[i]  = '0;
                n_upper[i] = '0;
            end else if (i == 0) begin
                n_left[i]  = o_raw;
                n_upper[i] = b_byte;
            end else begin
                n_left[i]  = base_left[i-1];
                n_upper[i] = base_upper[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= '0;
                r_upper[i] <= '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= n_left[i];
                r_upper[i] <= n_upper[i];
            end
        end
    end

endmodule

@@ hw/rtl/png_scanline_unfilter_unit.sv @@
// PNG scanline unfilter unit: column tracking, line store read/write-back
// with forwarding, output register and APB registers.
// Depends on pngu_pkg, pngu_line_mem and pngu_predict.
//
//  channel  dir  transaction fields (low bit up)
//  s        in   tdata: filtered_byte[7:0]; tuser: filter_type[2:0], image_start[3]
//  m        out  tdata: pixel_byte[7:0]; tlast: row_end
//  apb      in   0x0 bytes_per_pixel[3:0], 0x4 row_bytes[13:0]
//
// One byte per cycle unless the output stalls. Input stage: line store read on accept;
// reconstruct stage: predict, write back and load the output register when it fires.
// Synchronous reset clears control and pixel history; the line store is not cleared.
// An output stall holds the reconstruct stage and then the input side.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // filtered_byte
    input  logic [3:0]                    i_s_tuser,   // filter_type[2:0], image_start[3]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // pixel_byte
    output logic                          o_m_tlast,   // row_end
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pngu_pkg::APB_AW-1:0]   paddr,
    input  logic [pngu_pkg::APB_DW-1:0]   pwdata,
    output logic [pngu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int RBW = ($clog2(MAX_ROW_BYTES + 1) > pngu_pkg::ROW_W)
                         ? $clog2(MAX_ROW_BYTES + 1) : pngu_pkg::ROW_W;
    localparam logic [RBW-1:0] MaxRb = RBW'(MAX_ROW_BYTES);
    localparam logic [pngu_pkg::BPP_W-1:0] MaxBpp = pngu_pkg::BPP_W'(MAX_PIXEL_BYTES);

    logic [pngu_pkg::BPP_W-1:0]   r_bpp;
    logic [pngu_pkg::ROW_W-1:0]   r_row_bytes;
    logic [CW-1:0]                r_col;
    logic                         r_first_row;
    logic                         r_s1_valid;
    pngu_pkg::t_item_ctl          r_s1_ctl;
    logic [CW-1:0]                r_s1_col;
    logic [pngu_pkg::BYTE_W-1:0]  r_fwd_byte;
    logic                         r_out_valid;
    logic [pngu_pkg::BYTE_W-1:0]  r_out_byte;
    logic                         r_out_last;

    logic                         cfg_wr;
    logic                         s_accept;
    logic                         s1_fire;
    logic                         in_start;
    logic [RBW-1:0]               eff_rb;
    logic [RBW-1:0]               rb_ext;
    logic [RBW-1:0]               col_ext;
    logic [RBW-1:0]               col_c;
    logic [CW-1:0]                col;
    logic                         last;
    logic [pngu_pkg::BPP_W-1:0]   eff_bpp;
    logic [PW-1:0]                bpp_idx;
    logic [pngu_pkg::BYTE_W-1:0]  rd_byte;
    logic [pngu_pkg::BYTE_W-1:0]  raw;
    pngu_pkg::t_item_ctl          n_ctl;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= pngu_pkg::BPP_W'(1);
            r_row_bytes <= pngu_pkg::ROW_W'(1);
        end else if (cfg_wr) begin
            case (pngu_pkg::t_reg_idx'(paddr[2]))
                pngu_pkg::REG_BPP: r_bpp       <= pwdata[pngu_pkg::BPP_W-1:0];
                pngu_pkg::REG_ROW: r_row_bytes <= pwdata[pngu_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (pngu_pkg::t_reg_idx'(paddr[2]))
            pngu_pkg::REG_BPP: prdata = pngu_pkg::APB_DW'(r_bpp);
            pngu_pkg::REG_ROW: prdata = pngu_pkg::APB_DW'(r_row_bytes);
            default:           prdata = '0;
        endcase
    end

    // effective geometry
    always_comb begin
        if (r_bpp == '0) begin
            eff_bpp = pngu_pkg::BPP_W'(1);
        end else if (r_bpp > MaxBpp) begin
            eff_bpp = MaxBpp;
        end else begin
            eff_bpp = r_bpp;
        end
        bpp_idx = PW'(eff_bpp - pngu_pkg::BPP_W'(1));

        rb_ext = RBW'(r_row_bytes);
        if (rb_ext == '0) begin
            eff_rb = RBW'(1);
        end else if (rb_ext > MaxRb) begin
            eff_rb = MaxRb;
        end else begin
            eff_rb = rb_ext;
        end
    end

    // input stage: column, row flags, line store read
    assign s1_fire    = r_s1_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_s1_valid | s1_fire;
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign in_start   = i_s_tuser[pngu_pkg::FTYPE_W];

    always_comb begin
        col_ext = in_start ? '0 : RBW'(r_col);
        col_c   = (col_ext >= eff_rb) ? (eff_rb - RBW'(1)) : col_ext;
        col     = col_c[CW-1:0];
        last    = (col_c == (eff_rb - RBW'(1)));
        n_ctl.start     = in_start;
        n_ctl.first_row = in_start | r_first_row;
        n_ctl.last      = last;
        n_ctl.fwd       = s1_fire & (r_s1_col == col);
        n_ctl.ftype     = pngu_pkg::t_filter'(i_s_tuser[pngu_pkg::FTYPE_W-1:0]);
        n_ctl.xbyte     = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_s1_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_col       <= last ? '0 : col + CW'(1);
                r_first_row <= last ? 1'b0 : n_ctl.first_row;
            end
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_ctl   <= n_ctl;
            r_s1_col   <= col;
            r_fwd_byte <= raw;
        end
    end

    pngu_line_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (CW),
        .DW    (pngu_pkg::BYTE_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (col),
        .o_rd_data (rd_byte),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (raw)
    );

    pngu_predict #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .PW              (PW)
    ) u_predict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_ctl      (r_s1_ctl),
        .i_rd_byte  (rd_byte),
        .i_fwd_byte (r_fwd_byte),
        .i_bpp_idx  (bpp_idx),
        .o_raw      (raw)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_byte <= raw;
            r_out_last <= r_s1_ctl.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for png_scanline_unfilter_unit: streams filtered scanline bytes in,
// reprograms the APB registers between images and checks every reconstructed byte
// against an in-bench predictor or a directed expected value. Depends on pngu_pkg and the unit's RTL.
module testbench;

    localparam int ROW_LIMIT   = 8192;
    localparam int PIX_LIMIT   = 8;
    localparam int MAX_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 490;

    localparam logic [2:0] FILT_BAD_LO  = 3'd5;
    localparam logic [2:0] FILT_BAD_MID = 3'd6;
    localparam logic [2:0] FILT_BAD_HI  = 3'd7;

    typedef struct {
        logic [7:0] pixel;
        logic       row_end;
    } t_px_result;

    typedef struct {
        logic [7:0]  fb;
        logic [2:0]  ft;
        bit          st;
        logic [3:0]  bpp;
        logic [13:0] rowlen;
        bit          typed;
        logic [7:0]  px;
        bit          eol;
    } t_dir_row;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic [7:0]                    i_s_tdata  = '0;  // filtered_byte
    logic [3:0]                    i_s_tuser  = '0;  // filter_type[2:0], image_start[3]
    logic                          i_m_tready = 1'b0;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [pngu_pkg::APB_AW-1:0]   paddr      = '0;
    logic [pngu_pkg::APB_DW-1:0]   pwdata     = '0;
    wire                           o_s_tready;
    wire                           o_m_tvalid;
    wire  [7:0]                    o_m_tdata;        // pixel_byte
    wire                           o_m_tlast;        // row_end
    wire  [pngu_pkg::APB_DW-1:0]   prdata;
    wire                           pready;

    // predictor state
    logic [7:0]  prior_row [ROW_LIMIT];
    logic [7:0]  left_hist [PIX_LIMIT]  = '{default: '0};
    logic [7:0]  above_hist [PIX_LIMIT] = '{default: '0};
    int          col_pos   = 0;
    bit          first_row = 1'b1;
    logic [3:0]  cfg_bpp   = 4'd1;
    logic [13:0] cfg_row   = 14'd1;

    t_px_result  pending_px [$];
    int          mismatches  = 0;
    int          cycle_cnt   = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    bit          rx_hold_req = 1'b0;

    t_dir_row dir_rows [24] = '{
        '{8'hFF, pngu_pkg::FILT_NONE,  1'b1, 4'd1, 14'd1, 1'b1, 8'hFF, 1'b1},
        '{8'h01, pngu_pkg::FILT_UP,    1'b0, 4'd1, 14'd1, 1'b1, 8'h00, 1'b1},
        '{8'h80, pngu_pkg::FILT_SUB,   1'b0, 4'd1, 14'd1, 1'b1, 8'h80, 1'b1},
        '{8'h7F, pngu_pkg::FILT_AVG,   1'b0, 4'd1, 14'd1, 1'b1, 8'hBF, 1'b1},
        '{8'h00, pngu_pkg::FILT_PAETH, 1'b0, 4'd1, 14'd1, 1'b1, 8'hBF, 1'b1},
        '{8'h10, FILT_BAD_HI,          1'b1, 4'd1, 14'd1, 1'b1, 8'h10, 1'b1},
        '{8'hFF, pngu_pkg::FILT_UP,    1'b0, 4'd1, 14'd1, 1'b1, 8'h0F, 1'b1},
        '{8'h55, pngu_pkg::FILT_SUB,   1'b1, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hAA, pngu_pkg::FILT_SUB,   1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h01, pngu_pkg::FILT_AVG,   1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hFE, pngu_pkg::FILT_PAETH, 1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h12, pngu_pkg::FILT_UP,    1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h34, pngu_pkg::FILT_AVG,   1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h56, pngu_pkg::FILT_PAETH, 1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h78, pngu_pkg::FILT_PAETH, 1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h9A, FILT_BAD_LO,          1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hBC, FILT_BAD_MID,         1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hDE, pngu_pkg::FILT_SUB,   1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hF0, pngu_pkg::FILT_PAETH, 1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h00, pngu_pkg::FILT_AVG,   1'b1, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'hFF, pngu_pkg::FILT_PAETH, 1'b0, 4'd2, 14'd4, 1'b0, 8'h00, 1'b0},
        '{8'h3C, pngu_pkg::FILT_SUB,   1'b1, 4'hF, 14'd3, 1'b0, 8'h00, 1'b0},
        '{8'hC3, pngu_pkg::FILT_AVG,   1'b0, 4'hF, 14'd3, 1'b0, 8'h00, 1'b0},
        '{8'h99, pngu_pkg::FILT_PAETH, 1'b0, 4'hF, 14'd3, 1'b0, 8'h00, 1'b0}
    };

    png_scanline_unfilter_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pix_bytes();
        if (cfg_bpp == 4'd0) return 1;
        if (cfg_bpp > PIX_LIMIT) return PIX_LIMIT;
        return int'(cfg_bpp);
    endfunction

    function automatic int line_len();
        if (cfg_row == 14'd0) return 1;
        if (cfg_row > ROW_LIMIT) return ROW_LIMIT;
        return int'(cfg_row);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int pa;
        int pb;
        int pc;
        pa = int'(b) - int'(c);
        pb = int'(a) - int'(c);
        pc = int'(a) + int'(b) - 2 * int'(c);
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    function automatic t_px_result unfilter_byte(input logic [7:0] fb, input logic [2:0] ft,
                                                 input bit st);
        t_px_result res;
        int         bpp;
        int         rlen;
        int         col;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] pred;
        if (st) begin
            col_pos    = 0;
            first_row  = 1'b1;
            left_hist  = '{default: '0};
            above_hist = '{default: '0};
        end
        bpp  = pix_bytes();
        rlen = line_len();
        col  = col_pos;
        if (col >= rlen) col = rlen - 1;
        a = left_hist[bpp-1];
        c = above_hist[bpp-1];
        b = first_row ? 8'h00 : prior_row[col];
        case (ft)
            pngu_pkg::FILT_SUB:   pred = a;
            pngu_pkg::FILT_UP:    pred = b;
            pngu_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
            default:              pred = 8'h00;
        endcase
        res.pixel = fb + pred;
        prior_row[col] = res.pixel;
        for (int i = PIX_LIMIT - 1; i > 0; i--) begin
            left_hist[i]  = left_hist[i-1];
            above_hist[i] = above_hist[i-1];
        end
        left_hist[0]  = res.pixel;
        above_hist[0] = b;
        res.row_end = (col + 1 >= rlen);
        if (res.row_end) begin
            col_pos    = 0;
            first_row  = 1'b0;
            left_hist  = '{default: '0};
            above_hist = '{default: '0};
        end else begin
            col_pos = col + 1;
        end
        return res;
    endfunction

    task automatic push_byte(input logic [7:0] fb, input logic [2:0] ft, input bit st,
                             input bit typed, input logic [7:0] px, input bit eol);
        int         gap;
        t_px_result res;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= fb;
        i_s_tuser  <= {st, ft};
        do @(posedge i_clk); while (!o_s_tready);
        res = unfilter_byte(fb, ft, st);
        if (typed) begin
            res.pixel   = px;
            res.row_end = eol;
        end
        pending_px.push_back(res);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input pngu_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] want;
        want = (idx == pngu_pkg::REG_BPP) ? (value & 32'h0000_000F)
                                          : (value & 32'h0000_3FFF);
        drain_results();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            if (mismatches < 10)
                $display("register %s readback: exp %h got %h", idx.name(), want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == pngu_pkg::REG_BPP) cfg_bpp = value[3:0];
        else cfg_row = value[13:0];
    endtask

    // one image: rows of a single filter with random bytes, some rows scrambled
    task automatic run_image(input int n_items);
        int         rlen;
        int         done;
        logic [2:0] row_ft;
        logic [2:0] ft;
        bit         scrambled;
        bit         st;
        rlen = line_len();
        done = 0;
        while (done < n_items) begin
            row_ft    = 3'($urandom_range(0, 4));
            scrambled = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < rlen && done < n_items; k++) begin
                st = (done == 0) || (rlen < 64 && $urandom_range(0, 149) == 0);
                ft = scrambled ? 3'($urandom_range(0, 7)) : row_ft;
                push_byte(8'($urandom()), ft, st, 1'b0, 8'h00, 1'b0);
                done++;
            end
        end
    endtask

    initial begin : rx_side
        int         gap;
        t_px_result want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (pending_px.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected transaction: pixel_byte %h row_end %b",
                             o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want = pending_px.pop_front();
                if (o_m_tdata !== want.pixel || o_m_tlast !== want.row_end) begin
                    if (mismatches < 10)
                        $display("cycle %0d: pixel_byte exp %h got %h, row_end exp %b got %b",
                                 cycle_cnt, want.pixel, o_m_tdata, want.row_end, o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int          img_items;
        int          rand_items;
        logic [3:0]  new_bpp;
        logic [13:0] new_row;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].bpp != cfg_bpp)
                write_reg(pngu_pkg::REG_BPP, 32'(dir_rows[k].bpp));
            if (dir_rows[k].rowlen != cfg_row)
                write_reg(pngu_pkg::REG_ROW, 32'(dir_rows[k].rowlen));
            push_byte(dir_rows[k].fb, dir_rows[k].ft, dir_rows[k].st,
                      dir_rows[k].typed, dir_rows[k].px, dir_rows[k].eol);
        end

        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       new_bpp = 4'd0;
                1:       new_bpp = 4'hF;
                2:       new_bpp = 4'd8;
                default: new_bpp = 4'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       new_row = 14'd0;
                1:       new_row = 14'd1;
                default: new_row = 14'($urandom_range(2, 24));
            endcase
            write_reg(pngu_pkg::REG_BPP, 32'(new_bpp));
            write_reg(pngu_pkg::REG_ROW, 32'(new_row));
            tx_quiet  = ($urandom_range(0, 4) == 0);
            rx_quiet  = ($urandom_range(0, 4) == 0);
            img_items = $urandom_range(20, 60);
            // stall the output for a long stretch so the input backs up
            if (rand_items == 0) begin
                tx_quiet    = 1'b1;
                rx_hold_req = 1'b1;
            end
            run_image(img_items);
            rand_items += img_items;
        end

        // widest row: start of a clamped full-length line
        write_reg(pngu_pkg::REG_BPP, 32'd8);
        write_reg(pngu_pkg::REG_ROW, 32'h0000_3FFF);
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        run_image(20);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_px.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
